>>> sv/tsp_pkg.sv
// Shared types and constants for the TLV stream parser.
package tsp_pkg;

  localparam logic [7:0] TYPE_MASK   = 8'h1F;
  localparam logic [4:0] SIZE_MASK   = 5'h03;
  localparam logic [7:0] TAGCTL_MASK = 8'h07;

  localparam logic [2:0] TC_ANON    = 3'd0;
  localparam logic [2:0] TC_CONTEXT = 3'd1;

  localparam logic [1:0] SIZE_EIGHT = 2'd3;

  localparam logic [4:0] TY_SINT     = 5'h00;
  localparam logic [4:0] TY_UINT     = 5'h04;
  localparam logic [4:0] TY_FALSE    = 5'h08;
  localparam logic [4:0] TY_TRUE     = 5'h09;
  localparam logic [4:0] TY_FLOAT    = 5'h0A;
  localparam logic [4:0] TY_UTF8     = 5'h0C;
  localparam logic [4:0] TY_BYTES    = 5'h10;
  localparam logic [4:0] TY_NULL     = 5'h14;
  localparam logic [4:0] TY_STRUCT   = 5'h15;
  localparam logic [4:0] TY_ARRAY    = 5'h16;
  localparam logic [4:0] TY_LIST     = 5'h17;
  localparam logic [4:0] TY_END      = 5'h18;
  localparam logic [4:0] TY_RESERVED = 5'h19;

  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_ERROR   = 2'd2
  } result_kind_e;

  typedef enum logic [3:0] {
    EK_SINT   = 4'd0,
    EK_UINT   = 4'd1,
    EK_BOOL   = 4'd2,
    EK_UTF8   = 4'd3,
    EK_BYTES  = 4'd4,
    EK_NULL   = 4'd5,
    EK_STRUCT = 4'd6,
    EK_ARRAY  = 4'd7,
    EK_LIST   = 4'd8,
    EK_END    = 4'd9
  } elem_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RESERVED  = 3'd1,
    ERR_TAG_FORM  = 3'd2,
    ERR_LENGTH    = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_code_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    elem_kind_e   element_kind;
    logic         has_context_tag;
    logic [7:0]   tag_number;
    logic [63:0]  scalar_value;
    logic [1:0]   value_size_code;
    logic [31:0]  string_length;
    logic [7:0]   payload_byte;
    err_code_e    error_code;
    logic         element_done;
  } out_item_t;

  typedef struct packed {
    elem_kind_e kind;
    err_code_e  err;
    logic       ctx;
    logic [1:0] size;
    logic       bool_bit;
  } ctrl_dec_t;

endpackage

>>> sv/tsp_ctrl_dec.sv
// Control byte decoder: element kind, tag form, size code and decode errors.
module tsp_ctrl_dec (
  input  logic [7:0]         ctrl_byte_i,
  output tsp_pkg::ctrl_dec_t dec_o
);
  import tsp_pkg::*;

  logic [4:0] typ;
  logic [2:0] tc;

  assign typ = 5'(ctrl_byte_i & TYPE_MASK);
  assign tc  = 3'((ctrl_byte_i >> 5) & TAGCTL_MASK);

  always_comb begin
    dec_o          = '0;
    dec_o.size     = 2'(typ & SIZE_MASK);
    dec_o.ctx      = (tc == TC_CONTEXT);
    dec_o.bool_bit = 1'b0;
    dec_o.kind     = EK_SINT;
    dec_o.err      = ERR_NONE;
    unique case (typ) inside
      [5'h00:5'h03]: dec_o.kind = EK_SINT;
      [5'h04:5'h07]: dec_o.kind = EK_UINT;
      [5'h08:5'h09]: begin
        dec_o.kind     = EK_BOOL;
        dec_o.bool_bit = typ[0];
      end
      [5'h0C:5'h0F]: dec_o.kind = EK_UTF8;
      [5'h10:5'h13]: dec_o.kind = EK_BYTES;
      5'h14:         dec_o.kind = EK_NULL;
      5'h15:         dec_o.kind = EK_STRUCT;
      5'h16:         dec_o.kind = EK_ARRAY;
      5'h17:         dec_o.kind = EK_LIST;
      5'h18:         dec_o.kind = EK_END;
      default:       dec_o.err  = ERR_RESERVED;
    endcase
    if (dec_o.err == ERR_NONE && tc != TC_ANON && tc != TC_CONTEXT) begin
      dec_o.err = ERR_TAG_FORM;
    end
    if (dec_o.err == ERR_NONE && (dec_o.kind == EK_UTF8 || dec_o.kind == EK_BYTES)
        && dec_o.size == SIZE_EIGHT) begin
      dec_o.err = ERR_LENGTH;
    end
  end

endmodule

>>> sv/tsp_engine.sv
// Parser state and the combinational step logic for one stream byte.
module tsp_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tsp_pkg::in_item_t   item_i,
  output logic                res_valid_o,
  output tsp_pkg::out_item_t  res_o
);
  import tsp_pkg::*;

  localparam logic [2:0] PH_CTRL    = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  elem_kind_e  kind_q, kind_d;
  logic [1:0]  size_q, size_d;
  logic [8:0]  tag_q, tag_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic        drop_q, drop_d;

  ctrl_dec_t   dec;
  logic [7:0]  b;
  logic        last;
  logic        emit;
  err_code_e   err;
  logic        at_go;
  elem_kind_e  at_kind;
  logic [8:0]  at_tag;
  logic [1:0]  at_size;
  logic        at_bool;
  logic [3:0]  total;
  logic [2:0]  pos;
  logic [3:0]  bl_new;
  logic [63:0] acc_new;
  logic [31:0] pl_new;

  assign b    = item_i.stream_byte;
  assign last = item_i.end_of_stream;

  tsp_ctrl_dec u_ctrl_dec (
    .ctrl_byte_i (b),
    .dec_o       (dec)
  );

  assign total   = 4'd1 << size_q;
  assign pos     = 3'(total - bytes_left_q);
  assign bl_new  = bytes_left_q - 4'd1;
  assign acc_new = acc_q | (64'(b) << {pos, 3'b000});
  assign pl_new  = payload_left_q - 32'd1;

  always_comb begin
    phase_d        = phase_q;
    bytes_left_d   = bytes_left_q;
    kind_d         = kind_q;
    size_d         = size_q;
    tag_d          = tag_q;
    acc_d          = acc_q;
    payload_left_d = payload_left_q;
    drop_d         = drop_q;
    emit           = 1'b0;
    res_o          = '0;
    err            = ERR_NONE;
    at_go          = 1'b0;
    at_kind        = kind_q;
    at_tag         = tag_q;
    at_size        = size_q;
    at_bool        = acc_q[0];

    if (drop_q) begin
      if (last) begin
        drop_d  = 1'b0;
        phase_d = PH_CTRL;
      end
    end else begin
      unique case (phase_q)
        PH_TAG: begin
          tag_d  = {1'b1, b};
          at_go  = 1'b1;
          at_tag = {1'b1, b};
        end
        PH_VALUE: begin
          acc_d        = acc_new;
          bytes_left_d = bl_new;
          if (bl_new == 4'd0) begin
            emit                  = 1'b1;
            res_o.result_kind     = RK_HEADER;
            res_o.element_kind    = kind_q;
            res_o.has_context_tag = tag_q[8];
            res_o.tag_number      = tag_q[7:0];
            res_o.scalar_value    = acc_new;
            res_o.value_size_code = size_q;
            res_o.element_done    = 1'b1;
            phase_d               = PH_CTRL;
          end
        end
        PH_LEN: begin
          acc_d        = acc_new;
          bytes_left_d = bl_new;
          if (bl_new == 4'd0) begin
            payload_left_d        = acc_new[31:0];
            emit                  = 1'b1;
            res_o.result_kind     = RK_HEADER;
            res_o.element_kind    = kind_q;
            res_o.has_context_tag = tag_q[8];
            res_o.tag_number      = tag_q[7:0];
            res_o.string_length   = acc_new[31:0];
            res_o.element_done    = (acc_new[31:0] == 32'd0);
            phase_d = (acc_new[31:0] == 32'd0) ? PH_CTRL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          payload_left_d        = pl_new;
          emit                  = 1'b1;
          res_o.result_kind     = RK_PAYLOAD;
          res_o.element_kind    = kind_q;
          res_o.has_context_tag = tag_q[8];
          res_o.tag_number      = tag_q[7:0];
          res_o.payload_byte    = b;
          res_o.element_done    = (pl_new == 32'd0);
          if (pl_new == 32'd0) begin
            phase_d = PH_CTRL;
          end
        end
        default: begin
          phase_d = PH_CTRL;
          size_d  = dec.size;
          acc_d   = {63'd0, dec.bool_bit};
          err     = dec.err;
          if (dec.err == ERR_NONE) begin
            kind_d = dec.kind;
            tag_d  = 9'd0;
            if (dec.ctx) begin
              phase_d = PH_TAG;
            end else begin
              at_go   = 1'b1;
              at_kind = dec.kind;
              at_tag  = 9'd0;
              at_size = dec.size;
              at_bool = dec.bool_bit;
            end
          end
        end
      endcase

      if (at_go) begin
        if (at_kind == EK_SINT || at_kind == EK_UINT || at_kind == EK_UTF8
            || at_kind == EK_BYTES) begin
          bytes_left_d = 4'd1 << at_size;
          acc_d        = 64'd0;
          phase_d      = (at_kind == EK_SINT || at_kind == EK_UINT) ? PH_VALUE : PH_LEN;
        end else begin
          emit                  = 1'b1;
          res_o.result_kind     = RK_HEADER;
          res_o.element_kind    = at_kind;
          res_o.has_context_tag = at_tag[8];
          res_o.tag_number      = at_tag[7:0];
          res_o.scalar_value    = {63'd0, (at_kind == EK_BOOL) && at_bool};
          res_o.element_done    = 1'b1;
          phase_d               = PH_CTRL;
        end
      end

      if (err != ERR_NONE) begin
        emit               = 1'b1;
        res_o              = '0;
        res_o.result_kind  = RK_ERROR;
        res_o.error_code   = err;
        res_o.element_done = 1'b1;
        phase_d            = PH_CTRL;
        drop_d             = !last;
      end else if (last) begin
        if (phase_d != PH_CTRL) begin
          emit               = 1'b1;
          res_o              = '0;
          res_o.result_kind  = RK_ERROR;
          res_o.error_code   = ERR_TRUNCATED;
          res_o.element_done = 1'b1;
        end
        phase_d        = PH_CTRL;
        bytes_left_d   = 4'd0;
        payload_left_d = 32'd0;
        drop_d         = 1'b0;
      end
    end
  end

  assign res_valid_o = fire_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_CTRL;
      bytes_left_q   <= 4'd0;
      kind_q         <= EK_SINT;
      size_q         <= 2'd0;
      tag_q          <= 9'd0;
      acc_q          <= 64'd0;
      payload_left_q <= 32'd0;
      drop_q         <= 1'b0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      kind_q         <= kind_d;
      size_q         <= size_d;
      tag_q          <= tag_d;
      acc_q          <= acc_d;
      payload_left_q <= payload_left_d;
      drop_q         <= drop_d;
    end
  end

endmodule

>>> sv/tlv_stream_parser_core.sv
// TLV parser: one byte in per cycle unless stalled; element headers, payload bytes and errors out.
// Takes one byte of a TLV stream per transfer and returns at most one result per byte: an
// element header once the control byte, any context tag and any integer value or length
// prefix are in, one result per string payload byte, or an error. The sustained rate is one
// byte per cycle while the output register is not stalled; while a byte sits in the input
// register, the parser state is updated in a single step, and its result appears from the
// output register the next cycle. A stalled output register holds the byte in the input
// register, and the input takes a new byte whenever that register empties in the same cycle.
module tlv_stream_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsp_pkg::out_item_t out_item_o
);
  import tsp_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      proc;
  logic      res_valid;
  out_item_t res;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  tsp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (proc),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted byte not held in input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q || out_ready_i)
    else $error("result written over an untaken result");

  a_error_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == RK_ERROR |->
      out_item_o.element_done && out_item_o.error_code != ERR_NONE)
    else $error("error result without code or completion");

  a_payload_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == RK_PAYLOAD |->
      out_item_o.element_kind == EK_UTF8 || out_item_o.element_kind == EK_BYTES)
    else $error("payload result outside a string element");

endmodule
